### rtl/lin_frame_receiver_core_assert.svh
// Assertion helpers for the LIN frame receiver; clk and arst_n come from the
// module that uses them.
`ifndef LIN_FRAME_RECEIVER_CORE_ASSERT_SVH
`define LIN_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lin frame receiver: check failed");

// Next-cycle implication.
`define LFR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lin frame receiver: check failed");

`endif

### rtl/lfr_pkg.sv
package lfr_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_BREAK = 2'd1,
		FUNC_IDLE  = 2'd2,
		FUNC_FAULT = 2'd3
	} lfr_func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} lfr_item_t;

	typedef struct packed {
		logic [7:0] frame_pid;
		logic [3:0] frame_length;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
		logic [7:0] byte6;
		logic [7:0] byte7;
		logic [7:0] received_sum;
		logic       sum_ok;
	} lfr_frame_t;

	// write and clear requests toward the frame store
	typedef struct packed {
		logic       wr_en;
		logic [3:0] wr_addr;
		logic [7:0] wr_data;
		logic       clr;
	} lfr_store_ctl_t;

endpackage

### rtl/lin_frame_receiver_core.sv
// LIN frame receiver, enhanced checksum.
// Input channel (item, item_valid, item_stall): one word per UART event,
// func selects byte, break, idle or fault; rx_byte matters for bytes only.
// Output channel (frame, frame_valid, frame_stall): one word per rebuilt frame
// with PID, data length, the eight stored bytes, the received checksum byte
// and the enhanced checksum match flag.
// An event that emits no frame leaves the block ready for the next. After an
// emitting event the checksum is summed one stored byte per cycle through a
// single end-around-carry adder, then the output step moves the result into
// the output register. item_stall is high during that time. The output register
// holds a finished frame while the next event is taken; if the receiver stalls
// and a second frame is ready, the block waits in its output step, keeping
// item_stall high, until the first is taken.
// Reset clears the receiver to disarmed, count zero, PID and store zero, and
// drops any pending output word.
`include "lin_frame_receiver_core_assert.svh"

module lin_frame_receiver_core
	import lfr_pkg::*;
#(
	parameter int MAX_DATA = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lfr_item_t  item,
	input  logic       item_valid,
	output logic       item_stall,
	output lfr_frame_t frame,
	output logic       frame_valid,
	input  logic       frame_stall
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_OUT
	} state_t;

	localparam logic [3:0] CNT_LAST = 4'(MAX_DATA + 2);
	localparam logic [3:0] LEN_MAX  = 4'(MAX_DATA);

	state_t         state_q;
	logic           armed_q;
	logic [3:0]     count_q;
	logic [7:0]     pid_q;
	logic [3:0]     len_q;
	logic           short_q;
	logic           clear_q;
	logic [3:0]     idx_q;
	logic [7:0]     acc_q;
	logic [7:0]     rsum_q;
	logic           ok_q;
	lfr_frame_t     frame_q;
	logic           frame_valid_q;

	logic           accept;
	logic           store_byte;
	logic           emit;
	logic           out_free;
	logic           finish;
	logic           brk_ev;
	logic           idle_ev;
	logic           ev_short;
	logic [3:0]     ev_len;
	lfr_store_ctl_t store_ctl;
	logic [7:0]     rd_data;
	logic [7:0][7:0] entries;
	logic [7:0]     sum_next;

	assign item_stall  = (state_q != S_IDLE);
	assign accept      = item_valid && !item_stall;
	assign frame       = frame_q;
	assign frame_valid = frame_valid_q;
	assign out_free    = !frame_valid_q || !frame_stall;
	assign finish      = (state_q == S_OUT) && out_free;

	assign brk_ev  = (item.func == FUNC_BREAK);
	assign idle_ev = (item.func == FUNC_IDLE);

	// a data byte lands in the store while the frame is still open
	assign store_byte = (item.func == FUNC_BYTE) && armed_q &&
		(count_q >= 4'd2) && (count_q <= CNT_LAST);

	assign emit = accept && ((store_byte && count_q == CNT_LAST) ||
		((brk_ev || idle_ev) && count_q != 4'd0));

	// length of the frame this event closes; a byte into the checksum slot fills it
	always_comb begin
		ev_short = 1'b0;
		ev_len   = 4'd0;
		if (store_byte) begin
			ev_len = LEN_MAX;
		end else if (count_q < 4'd3) begin
			ev_short = 1'b1;
		end else if ((count_q - 4'd3) > LEN_MAX) begin
			ev_len = LEN_MAX;
		end else begin
			ev_len = count_q - 4'd3;
		end
	end

	// break with nothing pending clears at once; otherwise after the frame is out
	always_comb begin
		store_ctl.wr_en   = accept && store_byte;
		store_ctl.wr_addr = count_q - 4'd2;
		store_ctl.wr_data = item.rx_byte;
		store_ctl.clr     = (accept && brk_ev && !emit) || (finish && clear_q);
	end

	lfr_frame_store #(
		.MAX_DATA(MAX_DATA)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.entries (entries)
	);

	lfr_sum_unit u_sum (
		.acc    (acc_q),
		.addend (rd_data),
		.sum    (sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			armed_q       <= 1'b0;
			count_q       <= 4'd0;
			pid_q         <= 8'd0;
			len_q         <= 4'd0;
			short_q       <= 1'b0;
			clear_q       <= 1'b0;
			idx_q         <= 4'd0;
			acc_q         <= 8'd0;
			rsum_q        <= 8'd0;
			ok_q          <= 1'b0;
			frame_q       <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			// load a finished frame, or drop the word once it is taken
			if (finish) frame_valid_q <= 1'b1;
			else if (!frame_stall) frame_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.func)
							FUNC_BYTE: begin
								if (armed_q) begin
									if (count_q == 4'd0) begin
										if (item.rx_byte == SYNC_BYTE) count_q <= 4'd1;
										else armed_q <= 1'b0;
									end else if (count_q == 4'd1) begin
										pid_q   <= item.rx_byte;
										count_q <= 4'd2;
									end else if (store_byte) begin
										count_q <= count_q + 4'd1;
									end
								end
							end
							FUNC_BREAK: begin
								count_q <= 4'd0;
								armed_q <= 1'b1;
								// hold the PID for the checksum if a frame goes out
								if (!emit) pid_q <= 8'd0;
							end
							FUNC_IDLE: begin
								armed_q <= 1'b0;
							end
							default: begin
								armed_q <= 1'b0;
								count_q <= 4'd0;
							end
						endcase
						if (emit) begin
							state_q <= S_SUM;
							idx_q   <= 4'd0;
							acc_q   <= pid_q;
							len_q   <= ev_len;
							short_q <= ev_short;
							clear_q <= brk_ev;
						end
					end
				end
				S_SUM: begin
					// advance one data byte per cycle; the slot at the length is the checksum
					if (idx_q == len_q) begin
						rsum_q  <= short_q ? 8'd0 : rd_data;
						ok_q    <= !short_q && (acc_q == rd_data);
						state_q <= S_OUT;
					end else begin
						acc_q <= sum_next;
						idx_q <= idx_q + 4'd1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						frame_q.frame_pid    <= pid_q;
						frame_q.frame_length <= len_q;
						frame_q.byte0        <= entries[0];
						frame_q.byte1        <= entries[1];
						frame_q.byte2        <= entries[2];
						frame_q.byte3        <= entries[3];
						frame_q.byte4        <= entries[4];
						frame_q.byte5        <= entries[5];
						frame_q.byte6        <= entries[6];
						frame_q.byte7        <= entries[7];
						frame_q.received_sum <= rsum_q;
						frame_q.sum_ok       <= ok_q;
						if (clear_q) pid_q <= 8'd0;
						clear_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`LFR_ASSERT_IMP(a_idx_bound, state_q == S_SUM, idx_q <= len_q)
	`LFR_ASSERT_IMP(a_len_bound, frame_valid_q, frame_q.frame_length <= LEN_MAX)
	`LFR_ASSERT_IMP(a_zero_len_ok, frame_valid_q && frame_q.sum_ok && frame_q.frame_length == 4'd0, frame_q.received_sum == frame_q.frame_pid)
	`LFR_ASSERT_NXT(a_emit_busy, emit, state_q == S_SUM)

endmodule

### rtl/lfr_sum_unit.sv
// Add with end-around carry: a carry out of bit 7 wraps back into bit 0.
module lfr_sum_unit
	import lfr_pkg::*;
(
	input  logic [7:0] acc,
	input  logic [7:0] addend,
	output logic [7:0] sum
);

	logic [8:0] raw;

	assign raw = {1'b0, acc} + {1'b0, addend};
	assign sum = raw[8] ? (raw[7:0] + 8'd1) : raw[7:0];

endmodule

### rtl/lfr_frame_store.sv
// Frame byte store: one write port, one read port at a chosen address,
// and the first eight entries brought out for the result word.
module lfr_frame_store
	import lfr_pkg::*;
#(
	parameter int MAX_DATA = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lfr_store_ctl_t  ctl,
	input  logic [3:0]      rd_addr,
	output logic [7:0]      rd_data,
	output logic [7:0][7:0] entries
);

	localparam int DEPTH = MAX_DATA + 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [3:0] LAST_ADDR = 4'(MAX_DATA);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) mem_q[i] <= '0;
		end else if (ctl.clr) begin
			for (int i = 0; i < DEPTH; i++) mem_q[i] <= '0;
		end else if (ctl.wr_en && ctl.wr_addr <= LAST_ADDR) begin
			mem_q[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
		end
	end

	assign rd_data = (rd_addr <= LAST_ADDR) ? mem_q[rd_addr[AW-1:0]] : 8'd0;

	// entries past the last slot of the store (the checksum slot) read as zero
	for (genvar g = 0; g < 8; g++) begin : g_ent
		if (g < DEPTH) begin : g_live
			assign entries[g] = mem_q[g];
		end else begin : g_zero
			assign entries[g] = 8'd0;
		end
	end

endmodule
